@@ hw/rtl/bpa_pkg.sv @@
// Shared types and codes of the buddy page allocator.
package bpa_pkg;

  localparam logic MODE_ALLOC = 1'b0;
  localparam logic MODE_FREE  = 1'b1;

  localparam logic [1:0] STAT_OK      = 2'd0;
  localparam logic [1:0] STAT_NOBLK   = 2'd1;
  localparam logic [1:0] STAT_BADFREE = 2'd2;

  typedef enum logic [4:0] {
    S_CLEAR,
    S_IDLE,
    S_WANT,
    S_FIND,
    S_TAKE,
    S_SPLIT,
    S_MARK,
    S_FR_RD,
    S_MG,
    S_MG_CHK,
    S_UL,
    S_UL_CHK,
    S_UL_FIX,
    S_PUSH,
    S_DONE
  } bpa_state_t;

  typedef struct packed {
    logic       valid;
    logic [1:0] status;
    logic       addr_ok;
  } bpa_res_t;

endpackage

@@ hw/rtl/bpa_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module bpa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ hw/rtl/bpa_ctrl.sv @@
// Sequencer of the allocator: free lists, page marks and block orders.
module bpa_ctrl #(
  parameter int ORDER_COUNT = 11,
  parameter int PAGE_BYTES  = 4096
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   start,
  input  logic                   mode,
  input  logic [31:0]            bytes,
  input  logic                   free_zero,
  input  logic                   free_bad,
  input  logic [ORDER_COUNT-2:0] free_off,
  output logic                   idle,
  output bpa_pkg::bpa_res_t      res,
  output logic [ORDER_COUNT-2:0] res_idx
);
  import bpa_pkg::*;

  localparam int IW    = ORDER_COUNT - 1;
  localparam int PAGES = 1 << IW;
  localparam int LW    = IW + 1;
  localparam int OW    = $clog2(ORDER_COUNT + 1);
  localparam int HW    = $clog2(ORDER_COUNT);
  localparam int MW    = $clog2(ORDER_COUNT + 2);
  localparam int PB_SH = $clog2(PAGE_BYTES);
  localparam int SW    = PB_SH + ORDER_COUNT + 1;
  localparam int CW    = (SW > 32) ? SW : 32;

  localparam logic [LW-1:0] NIL          = LW'(PAGES);
  localparam logic [MW-1:0] MARK_ALLOC   = MW'(ORDER_COUNT);
  localparam logic [MW-1:0] MARK_NOSTART = MW'(ORDER_COUNT + 1);
  localparam logic [OW-1:0] TOP_ORD      = OW'(ORDER_COUNT - 1);
  localparam logic [OW-1:0] ORD_END      = OW'(ORDER_COUNT);

  bpa_state_t st_r, st_nxt;
  logic [31:0]   bytes_r, bytes_nxt;
  logic [OW-1:0] want_r, want_nxt;
  logic [OW-1:0] ord_r, ord_nxt;
  logic [SW-1:0] sz_r, sz_nxt;
  logic [IW-1:0] idx_r, idx_nxt;
  logic [IW-1:0] bud_r, bud_nxt;
  logic [LW-1:0] cur_r, cur_nxt;
  logic [LW-1:0] prev_r, prev_nxt;
  logic [IW-1:0] mk_base_r, mk_base_nxt;
  logic [OW-1:0] mk_ord_r, mk_ord_nxt;
  logic [IW:0]   mk_cnt_r, mk_cnt_nxt;
  logic          mk_split_r, mk_split_nxt;
  logic [IW:0]   clr_r, clr_nxt;
  logic [LW-1:0] head_r [ORDER_COUNT];
  logic [LW-1:0] head_nxt [ORDER_COUNT];
  bpa_res_t      res_r, res_nxt;
  logic [IW-1:0] ridx_r, ridx_nxt;

  logic          nx_we, ord_we, mk_we;
  logic [IW-1:0] nx_wa, ord_wa, mk_wa, nx_ra, ord_ra, mk_ra;
  logic [LW-1:0] nx_wd, nx_rd;
  logic [OW-1:0] ord_wd, ord_rd;
  logic [MW-1:0] mk_wd, mk_rd;

  logic [OW-1:0] ordm;
  logic [IW-1:0] bud_c;
  logic [IW:0]   mk_len;

  bpa_ram #(.WIDTH(LW), .DEPTH(PAGES)) u_next (
    .clk(clk), .we(nx_we), .waddr(nx_wa), .wdata(nx_wd), .raddr(nx_ra), .rdata(nx_rd)
  );
  bpa_ram #(.WIDTH(OW), .DEPTH(PAGES)) u_order (
    .clk(clk), .we(ord_we), .waddr(ord_wa), .wdata(ord_wd), .raddr(ord_ra), .rdata(ord_rd)
  );
  bpa_ram #(.WIDTH(MW), .DEPTH(PAGES)) u_mark (
    .clk(clk), .we(mk_we), .waddr(mk_wa), .wdata(mk_wd), .raddr(mk_ra), .rdata(mk_rd)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r  <= S_CLEAR;
      clr_r <= '0;
      res_r <= '0;
      for (int i = 0; i < ORDER_COUNT; i++) begin
        head_r[i] <= (i == ORDER_COUNT - 1) ? '0 : NIL;
      end
    end else begin
      st_r  <= st_nxt;
      clr_r <= clr_nxt;
      res_r <= res_nxt;
      for (int i = 0; i < ORDER_COUNT; i++) begin
        head_r[i] <= head_nxt[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    bytes_r    <= bytes_nxt;
    want_r     <= want_nxt;
    ord_r      <= ord_nxt;
    sz_r       <= sz_nxt;
    idx_r      <= idx_nxt;
    bud_r      <= bud_nxt;
    cur_r      <= cur_nxt;
    prev_r     <= prev_nxt;
    mk_base_r  <= mk_base_nxt;
    mk_ord_r   <= mk_ord_nxt;
    mk_cnt_r   <= mk_cnt_nxt;
    mk_split_r <= mk_split_nxt;
    ridx_r     <= ridx_nxt;
  end

  always_comb begin
    st_nxt       = st_r;
    bytes_nxt    = bytes_r;
    want_nxt     = want_r;
    ord_nxt      = ord_r;
    sz_nxt       = sz_r;
    idx_nxt      = idx_r;
    bud_nxt      = bud_r;
    cur_nxt      = cur_r;
    prev_nxt     = prev_r;
    mk_base_nxt  = mk_base_r;
    mk_ord_nxt   = mk_ord_r;
    mk_cnt_nxt   = mk_cnt_r;
    mk_split_nxt = mk_split_r;
    clr_nxt      = clr_r;
    ridx_nxt     = ridx_r;
    res_nxt      = res_r;
    res_nxt.valid = 1'b0;
    for (int i = 0; i < ORDER_COUNT; i++) begin
      head_nxt[i] = head_r[i];
    end
    nx_we  = 1'b0;
    nx_wa  = '0;
    nx_wd  = NIL;
    nx_ra  = '0;
    ord_we = 1'b0;
    ord_wa = '0;
    ord_wd = '0;
    ord_ra = '0;
    mk_we  = 1'b0;
    mk_wa  = '0;
    mk_wd  = MARK_NOSTART;
    mk_ra  = '0;
    ordm   = ord_r - OW'(1);
    bud_c  = '0;
    mk_len = (IW + 1)'(1) << mk_ord_r;

    case (st_r)
      S_CLEAR: begin
        nx_we  = 1'b1;
        nx_wa  = clr_r[IW-1:0];
        nx_wd  = NIL;
        ord_we = 1'b1;
        ord_wa = clr_r[IW-1:0];
        ord_wd = (clr_r == '0) ? TOP_ORD : '0;
        mk_we  = 1'b1;
        mk_wa  = clr_r[IW-1:0];
        mk_wd  = (clr_r == '0) ? MW'(ORDER_COUNT - 1) : MARK_NOSTART;
        clr_nxt = clr_r + (IW + 1)'(1);
        if (clr_r == (IW + 1)'(PAGES - 1)) begin
          st_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (start) begin
          bytes_nxt = bytes;
          if (mode == MODE_ALLOC) begin
            want_nxt = '0;
            sz_nxt   = SW'(PAGE_BYTES);
            if (bytes == '0) begin
              res_nxt.status  = STAT_NOBLK;
              res_nxt.addr_ok = 1'b0;
              st_nxt = S_DONE;
            end else begin
              st_nxt = S_WANT;
            end
          end else begin
            res_nxt.addr_ok = 1'b0;
            idx_nxt = free_off;
            mk_ra   = free_off;
            ord_ra  = free_off;
            if (free_zero) begin
              res_nxt.status = STAT_OK;
              st_nxt = S_DONE;
            end else if (free_bad) begin
              res_nxt.status = STAT_BADFREE;
              st_nxt = S_DONE;
            end else begin
              st_nxt = S_FR_RD;
            end
          end
        end
      end
      S_WANT: begin
        if (want_r < ORD_END && CW'(sz_r) < CW'(bytes_r)) begin
          want_nxt = want_r + OW'(1);
          sz_nxt   = sz_r << 1;
        end else if (want_r == ORD_END) begin
          res_nxt.status  = STAT_NOBLK;
          res_nxt.addr_ok = 1'b0;
          st_nxt = S_DONE;
        end else begin
          ord_nxt = want_r;
          st_nxt  = S_FIND;
        end
      end
      S_FIND: begin
        if (ord_r == ORD_END) begin
          res_nxt.status  = STAT_NOBLK;
          res_nxt.addr_ok = 1'b0;
          st_nxt = S_DONE;
        end else if (head_r[ord_r[HW-1:0]] != NIL) begin
          idx_nxt = head_r[ord_r[HW-1:0]][IW-1:0];
          nx_ra   = head_r[ord_r[HW-1:0]][IW-1:0];
          st_nxt  = S_TAKE;
        end else begin
          ord_nxt = ord_r + OW'(1);
        end
      end
      S_TAKE: begin
        head_nxt[ord_r[HW-1:0]] = nx_rd;
        nx_we  = 1'b1;
        nx_wa  = idx_r;
        nx_wd  = NIL;
        st_nxt = S_SPLIT;
      end
      S_SPLIT: begin
        if (ord_r > want_r) begin
          bud_c  = idx_r ^ (IW'(1) << ordm);
          ord_we = 1'b1;
          ord_wa = bud_c;
          ord_wd = ordm;
          mk_we  = 1'b1;
          mk_wa  = bud_c;
          mk_wd  = MW'(ordm);
          nx_we  = 1'b1;
          nx_wa  = bud_c;
          nx_wd  = head_r[ordm[HW-1:0]];
          head_nxt[ordm[HW-1:0]] = LW'(bud_c);
          ord_nxt      = ordm;
          mk_base_nxt  = bud_c;
          mk_ord_nxt   = ordm;
          mk_split_nxt = 1'b1;
        end else begin
          ord_we = 1'b1;
          ord_wa = idx_r;
          ord_wd = want_r;
          mk_we  = 1'b1;
          mk_wa  = idx_r;
          mk_wd  = MARK_ALLOC;
          mk_base_nxt     = idx_r;
          mk_ord_nxt      = want_r;
          mk_split_nxt    = 1'b0;
          res_nxt.status  = STAT_OK;
          res_nxt.addr_ok = 1'b1;
          ridx_nxt        = idx_r;
        end
        mk_cnt_nxt = (IW + 1)'(1);
        st_nxt     = S_MARK;
      end
      S_MARK: begin
        if (mk_cnt_r < mk_len) begin
          mk_we      = 1'b1;
          mk_wa      = mk_base_r + mk_cnt_r[IW-1:0];
          mk_wd      = MARK_NOSTART;
          mk_cnt_nxt = mk_cnt_r + (IW + 1)'(1);
        end else begin
          st_nxt = mk_split_r ? S_SPLIT : S_DONE;
        end
      end
      S_FR_RD: begin
        if (mk_rd != MARK_ALLOC) begin
          res_nxt.status = STAT_BADFREE;
          st_nxt = S_DONE;
        end else begin
          ord_nxt = (ord_rd > TOP_ORD) ? TOP_ORD : ord_rd;
          st_nxt  = S_MG;
        end
      end
      S_MG: begin
        if (ord_r < TOP_ORD) begin
          bud_c   = idx_r ^ (IW'(1) << ord_r);
          bud_nxt = bud_c;
          mk_ra   = bud_c;
          st_nxt  = S_MG_CHK;
        end else begin
          st_nxt = S_PUSH;
        end
      end
      S_MG_CHK: begin
        if (mk_rd != MW'(ord_r)) begin
          st_nxt = S_PUSH;
        end else begin
          cur_nxt  = head_r[ord_r[HW-1:0]];
          prev_nxt = NIL;
          st_nxt   = S_UL;
        end
      end
      S_UL: begin
        if (cur_r == NIL) begin
          if (bud_r < idx_r) begin
            idx_nxt = bud_r;
          end
          ord_nxt = ord_r + OW'(1);
          st_nxt  = S_MG;
        end else begin
          nx_ra  = cur_r[IW-1:0];
          st_nxt = S_UL_CHK;
        end
      end
      S_UL_CHK: begin
        if (cur_r == LW'(bud_r)) begin
          if (prev_r == NIL) begin
            head_nxt[ord_r[HW-1:0]] = nx_rd;
          end else begin
            nx_we = 1'b1;
            nx_wa = prev_r[IW-1:0];
            nx_wd = nx_rd;
          end
          st_nxt = S_UL_FIX;
        end else begin
          prev_nxt = cur_r;
          cur_nxt  = nx_rd;
          st_nxt   = S_UL;
        end
      end
      S_UL_FIX: begin
        nx_we = 1'b1;
        nx_wa = bud_r;
        nx_wd = NIL;
        if (bud_r < idx_r) begin
          idx_nxt = bud_r;
        end
        ord_nxt = ord_r + OW'(1);
        st_nxt  = S_MG;
      end
      S_PUSH: begin
        ord_we = 1'b1;
        ord_wa = idx_r;
        ord_wd = ord_r;
        mk_we  = 1'b1;
        mk_wa  = idx_r;
        mk_wd  = MW'(ord_r);
        nx_we  = 1'b1;
        nx_wa  = idx_r;
        nx_wd  = head_r[ord_r[HW-1:0]];
        head_nxt[ord_r[HW-1:0]] = LW'(idx_r);
        mk_base_nxt     = idx_r;
        mk_ord_nxt      = ord_r;
        mk_cnt_nxt      = (IW + 1)'(1);
        mk_split_nxt    = 1'b0;
        res_nxt.status  = STAT_OK;
        res_nxt.addr_ok = 1'b0;
        st_nxt          = S_MARK;
      end
      S_DONE: begin
        res_nxt.valid = 1'b1;
        st_nxt        = S_IDLE;
      end
      default: begin
        st_nxt = S_IDLE;
      end
    endcase
  end

  assign idle    = (st_r == S_IDLE);
  assign res     = res_r;
  assign res_idx = ridx_r;

endmodule

@@ hw/rtl/buddy_page_allocator.sv @@
// Allocate: find the wanted order, search the free lists upward from it, then split the block down
// and mark its pages; zero bytes or no fitting block give STAT_NOBLK.
// Free: check the page mark, merge with each free buddy (unlinked by a walk of its free list), then
// push and mark the block; a zero address is ignored, one out of the zone or not allocated gives STAT_BADFREE.
// One request at a time: the next is taken once the result register and result path are empty.
// Reset is synchronous; afterwards a clearing pass over all 2^(ORDER_COUNT-1) pages runs.
// Top level of the buddy page allocator: request checks, zone base, result register.
module buddy_page_allocator #(
  parameter int ORDER_COUNT = 11,
  parameter int PAGE_BYTES  = 4096
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wr_en,
  input  logic [47:0] cfg_wr_data,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic        in_tuser,   // mode[0]
  input  logic [79:0] in_tdata,   // request_bytes[31:0], free_address[79:32]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [55:0] out_tdata   // block_address[47:0], status[49:48]
);
  import bpa_pkg::*;

  localparam int IW    = ORDER_COUNT - 1;
  localparam int PB_SH = $clog2(PAGE_BYTES);

  logic [47:0] zone_base_r, zone_base_nxt;
  logic        out_valid_r, out_valid_nxt;
  logic [47:0] out_addr_r, out_addr_nxt;
  logic [1:0]  out_stat_r, out_stat_nxt;

  logic          idle, start, free_zero, free_bad;
  logic [47:0]   fa, diff;
  logic [IW-1:0] res_idx;
  bpa_res_t      res;

  assign fa        = in_tdata[79:32];
  assign diff      = fa - zone_base_r;
  assign free_zero = (fa == '0);
  assign free_bad  = (|fa[PB_SH-1:0]) || (fa < zone_base_r) || (|diff[47:PB_SH+IW]);
  assign in_tready = idle && !out_valid_r && !res.valid;
  assign start     = in_tvalid && in_tready;

  bpa_ctrl #(.ORDER_COUNT(ORDER_COUNT), .PAGE_BYTES(PAGE_BYTES)) u_ctrl (
    .clk(clk),
    .rst_n(rst_n),
    .start(start),
    .mode(in_tuser),
    .bytes(in_tdata[31:0]),
    .free_zero(free_zero),
    .free_bad(free_bad),
    .free_off(diff[PB_SH+IW-1:PB_SH]),
    .idle(idle),
    .res(res),
    .res_idx(res_idx)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      zone_base_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      zone_base_r <= zone_base_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_addr_r <= out_addr_nxt;
    out_stat_r <= out_stat_nxt;
  end

  always_comb begin
    zone_base_nxt = cfg_wr_en ? cfg_wr_data : zone_base_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_addr_nxt  = out_addr_r;
    out_stat_nxt  = out_stat_r;
    if (res.valid) begin
      out_valid_nxt = 1'b1;
      out_stat_nxt  = res.status;
      out_addr_nxt  = res.addr_ok ? (zone_base_r + (48'(res_idx) << PB_SH)) : '0;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {6'd0, out_stat_r, out_addr_r};

endmodule

@@ hw/rtl/bpa_chk.sv @@
// Port-level checks of the buddy page allocator, bound to the top level.
module bpa_chk (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [55:0] out_tdata
);
  import bpa_pkg::*;

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("result dropped while stalled");

  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("request taken while busy");

  a_stat: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[49:48] == STAT_OK || out_tdata[49:48] == STAT_NOBLK ||
                    out_tdata[49:48] == STAT_BADFREE))
    else $error("bad status code");

  a_fail_addr: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[49:48] != STAT_OK |-> out_tdata[47:0] == 48'd0)
    else $error("address on failure");

  a_rst: assert property (@(posedge clk) !rst_n |=> !out_tvalid && !in_tready)
    else $error("active after reset");

endmodule

bind buddy_page_allocator bpa_chk u_bpa_chk (
  .clk(clk),
  .rst_n(rst_n),
  .in_tvalid(in_tvalid),
  .in_tready(in_tready),
  .out_tvalid(out_tvalid),
  .out_tready(out_tready),
  .out_tdata(out_tdata)
);
